FILE: rtl/mmae_pkg.sv
// Shared types and constants of the matrix multiply / add engine.
`default_nettype none

package mmae_pkg;

    // Width of the wide accumulator; holds a sum of up to eight shifted products
    localparam int ACC_W = 64;
    localparam int DATA_W = 32;
    localparam int DIM_W = 4;
    localparam int IDX_W = 3;

    // Operation codes of an input word
    typedef enum logic [1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_COMPUTE    = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_INNER_COLS = 2'd0;
    localparam logic [1:0] REG_OUT_ROWS   = 2'd1;
    localparam logic [1:0] REG_MODE       = 2'd2;

    // Control that travels along the MAC pipeline with each read
    typedef struct packed {
        logic rd_en;     // a read issued this cycle
        logic first;     // first term of an element: clear the accumulator
        logic last;      // last term of an element
        logic add_mode;  // element-wise add instead of multiply
    } t_mac_ctl;

    // Status back from the MAC
    typedef struct packed {
        logic done;      // accumulator holds a finished element
        logic ovf;       // finished element saturated
    } t_mac_stat;

endpackage

`default_nettype wire

FILE: rtl/matrix_multiply_add_engine_top.sv
// Top level: load/compute sequencer, configuration registers and result register.
// Loads are accepted back to back while idle; a compute word walks out_rows*inner_cols
// elements, each read one pair per cycle over k in multiply mode (a single pair in add mode)
// and then passed through the read/multiply/accumulate pipe.
// The result register frees the producer one element ahead of a stalled consumer.
// Synchronous active-low reset clears the sequencer and valids and sets both dimension
// registers to 8 and mode to 0; memories keep data.
`default_nettype none

module matrix_multiply_add_engine_top
    import mmae_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input words
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_operation,
    input  wire logic [IDX_W-1:0]         i_row,
    input  wire logic [IDX_W-1:0]         i_col,
    input  wire logic signed [DATA_W-1:0] i_value,
    // result words
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [IDX_W-1:0]              o_out_row,
    output logic [IDX_W-1:0]              o_out_col,
    output logic signed [DATA_W-1:0]      o_out_value,
    output logic                          o_overflow,
    output logic                          o_last,
    // configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [3:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,  // taking words: loads write memory, compute starts a run
        S_ISSUE = 4'b0010,  // one read pair per cycle over k
        S_DRAIN = 4'b0100,  // wait for the accumulator to finish the element
        S_OUT   = 4'b1000   // hand the element to the result register
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_row, n_row;
    logic [IDX_W-1:0]   r_col, n_col;
    logic [IDX_W-1:0]   r_k, n_k;

    logic [DIM_W-1:0]   r_inner_cols;
    logic [DIM_W-1:0]   r_out_rows;
    logic               r_mode;

    logic               r_out_vld;
    logic [IDX_W-1:0]   r_out_row;
    logic [IDX_W-1:0]   r_out_col;
    logic signed [DATA_W-1:0] r_out_value;
    logic               r_out_ovf;
    logic               r_out_last;

    logic [DIM_W-1:0]   nc, nr;
    logic               in_acc;
    logic               load_ok;
    logic               wr_left, wr_right;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr_left, raddr_right;
    logic               k_last, col_last, row_last;
    logic               slot_free;
    logic               out_load;
    logic               cfg_wr;
    t_mac_ctl           mac_ctl;
    t_mac_stat          mac_stat;
    logic signed [DATA_W-1:0] mac_value;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_cols <= DIM_W'(8);
            r_out_rows   <= DIM_W'(8);
            r_mode       <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_INNER_COLS: r_inner_cols <= pwdata[DIM_W-1:0];
                REG_OUT_ROWS:   r_out_rows   <= pwdata[DIM_W-1:0];
                REG_MODE:       r_mode       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_INNER_COLS: prdata = {{(32-DIM_W){1'b0}}, r_inner_cols};
            REG_OUT_ROWS:   prdata = {{(32-DIM_W){1'b0}}, r_out_rows};
            REG_MODE:       prdata = {31'd0, r_mode};
            default:        prdata = '0;
        endcase
    end

    // Dimensions: zero reads as one, above MAX_DIM reads as MAX_DIM
    always_comb begin
        nc = r_inner_cols;
        if (r_inner_cols == '0) begin
            nc = DIM_W'(1);
        end else if (32'(r_inner_cols) > MAX_DIM) begin
            nc = DIM_W'(MAX_DIM);
        end
        nr = r_out_rows;
        if (r_out_rows == '0) begin
            nr = DIM_W'(1);
        end else if (32'(r_out_rows) > MAX_DIM) begin
            nr = DIM_W'(MAX_DIM);
        end
    end

    // ---------------- input side ----------------
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    // loads outside the matrix are dropped
    assign load_ok    = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);
    assign wr_left    = in_acc && load_ok && (i_operation == OP_LOAD_LEFT);
    assign wr_right   = in_acc && load_ok && (i_operation == OP_LOAD_RIGHT);
    assign waddr      = ADDR_W'(32'(i_row) * MAX_DIM + 32'(i_col));

    // ---------------- element walk ----------------
    // Multiply: right[r][k] * left[k][c]; add: left[r][c] + right[r][c]
    always_comb begin
        if (r_mode) begin
            raddr_left  = ADDR_W'(32'(r_row) * MAX_DIM + 32'(r_col));
            raddr_right = raddr_left;
        end else begin
            raddr_left  = ADDR_W'(32'(r_k) * MAX_DIM + 32'(r_col));
            raddr_right = ADDR_W'(32'(r_row) * MAX_DIM + 32'(r_k));
        end
    end

    assign k_last   = r_mode || ({1'b0, r_k} == nc - DIM_W'(1));
    assign col_last = ({1'b0, r_col} == nc - DIM_W'(1));
    assign row_last = ({1'b0, r_row} == nr - DIM_W'(1));

    assign mac_ctl.rd_en    = (r_state == S_ISSUE);
    assign mac_ctl.first    = (r_k == '0);
    assign mac_ctl.last     = k_last;
    assign mac_ctl.add_mode = r_mode;

    assign slot_free = !r_out_vld || i_out_ready;
    assign out_load  = (r_state == S_OUT) && slot_free;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_operation == OP_COMPUTE)) begin
                    n_state = S_ISSUE;
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                end
            end
            S_ISSUE: begin
                if (k_last) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (mac_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    n_state = S_ISSUE;
                    if (col_last) begin
                        n_col = '0;
                        if (row_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_row = r_row + IDX_W'(1);
                        end
                    end else begin
                        n_col = r_col + IDX_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    // ---------------- storage and MAC ----------------
    mmae_core #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_left     (wr_left),
        .i_wr_right    (wr_right),
        .i_waddr       (waddr),
        .i_wdata       (i_value),
        .i_ctl         (mac_ctl),
        .i_raddr_left  (raddr_left),
        .i_raddr_right (raddr_right),
        .o_stat        (mac_stat),
        .o_value       (mac_value)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_value <= mac_value;
            r_out_ovf   <= mac_stat.ovf;
            r_out_last  <= col_last && row_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_overflow  = r_out_ovf;
    assign o_last      = r_out_last;

    // ---------------- checks ----------------
    // accumulator finishes only while the sequencer waits for it
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_stat.done |-> (r_state == S_DRAIN))
        else $error("MAC finished outside drain");

    // a handed-off element shows up as a valid word
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("element lost at result register");

    // the final element of a run returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && col_last && row_last) |=> (r_state == S_IDLE))
        else $error("run did not end after last element");

    // k walk restarts from zero for every element
    a_k_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ISSUE) |-> (r_k == '0))
        else $error("k counter not cleared");

endmodule

`default_nettype wire

FILE: rtl/mmae_core.sv
// Matrix storage (left and right memories) and the multiply-accumulate pipeline.
`default_nettype none

module mmae_core
    import mmae_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int FRAC_BITS = 16,
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_left,
    input  wire logic                     i_wr_right,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic signed [DATA_W-1:0] i_wdata,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic [ADDR_W-1:0]        i_raddr_left,
    input  wire logic [ADDR_W-1:0]        i_raddr_right,
    output t_mac_stat                     o_stat,
    output logic signed [DATA_W-1:0]      o_value
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic signed [DATA_W-1:0] r_left_mem  [DEPTH];
    logic signed [DATA_W-1:0] r_right_mem [DEPTH];

    logic signed [DATA_W-1:0] r_left_q;
    logic signed [DATA_W-1:0] r_right_q;
    t_mac_ctl                 r_s1;
    t_mac_ctl                 r_s2;
    logic signed [ACC_W-1:0]  r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    logic signed [ACC_W-1:0]  prod;
    logic signed [ACC_W-1:0]  sum;
    logic                     ovf;

    // Left memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_left) begin
            r_left_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_left_q <= r_left_mem[i_raddr_left];
        end
    end

    // Right memory
    always_ff @(posedge i_clk) begin
        if (i_wr_right) begin
            r_right_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_right_q <= r_right_mem[i_raddr_right];
        end
    end

    // 32x32 signed product, floor-shifted by the fraction width
    assign prod = ACC_W'(r_left_q) * ACC_W'(r_right_q);
    assign sum  = {{(ACC_W-DATA_W){r_left_q[DATA_W-1]}}, r_left_q}
                + {{(ACC_W-DATA_W){r_right_q[DATA_W-1]}}, r_right_q};

    always_ff @(posedge i_clk) begin
        if (r_s1.rd_en) begin
            r_term <= r_s1.add_mode ? sum : (prod >>> FRAC_BITS);
        end
        if (r_s2.rd_en) begin
            r_acc <= (r_s2.first ? '0 : r_acc) + r_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= '0;
            r_s2   <= '0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_ctl;
            r_s2   <= r_s1;
            r_done <= r_s2.rd_en & r_s2.last;
        end
    end

    // Saturate to 32 bits: in range when bits [63:31] all agree
    assign ovf = !((&r_acc[ACC_W-1:DATA_W-1]) || !(|r_acc[ACC_W-1:DATA_W-1]));

    always_comb begin
        if (!ovf) begin
            o_value = r_acc[DATA_W-1:0];
        end else if (r_acc[ACC_W-1]) begin
            o_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = ovf;

endmodule

`default_nettype wire
